// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the divider, datapath and controller of the mollifier window block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sepmol_pkg.sv =====
// Package with the constants, types and helper functions of the mollifier window block.
package sepmol_pkg;

    localparam int MAX_MARGIN   = 256;
    localparam int MAX_SIZE     = 4096;
    localparam int ADDR_W       = $clog2(MAX_MARGIN);
    localparam int CNT_W        = $clog2(MAX_MARGIN + 1);
    localparam int SIZE_W       = 13;
    localparam int MARGIN_W     = 9;
    localparam int COORD_W      = 12;
    localparam int COEF_W       = 16;
    localparam int QP_W         = 2 * COEF_W;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int NUM_W        = 2 * ADDR_W;
    localparam int FRAC_W       = 32;
    localparam int PROD_W       = 2 * FRAC_W;
    localparam int SUM_W        = FRAC_W + 4;
    localparam int TOTAL_W      = FRAC_W + ADDR_W;
    localparam int DVD_W        = TOTAL_W + 16;
    localparam int DVS_W        = TOTAL_W;
    localparam int DIV_CNT_W    = $clog2(DVD_W + 1);
    localparam int TAYLOR_TERMS = 13;
    localparam int K_W          = $clog2(TAYLOR_TERMS + 1);

    localparam logic [COEF_W-1:0] ONE_Q15    = COEF_W'(1) << (COEF_W - 1);
    localparam logic [FRAC_W:0]   ONE_Q32    = {1'b1, {FRAC_W{1'b0}}};
    localparam logic [FRAC_W-1:0] EXP_M1_Q32 = 32'd1580030169;
    localparam logic [PROD_W:0]   HALF_Q32   = (PROD_W + 1)'(1) << (FRAC_W - 1);
    localparam logic [QP_W-1:0]   HALF_Q15   = QP_W'(1) << (COEF_W - 2);

    localparam logic OP_PREPARE = 1'b0;
    localparam logic OP_QUERY   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_MARGIN_X     = 2'd2,
        REG_MARGIN_Y     = 2'd3
    } cfg_reg_t;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_AXIS_INIT,
        DP_EDGE_WRITE,
        DP_DEN,
        DP_DIV_N,
        DP_DIV_F,
        DP_TAYLOR1,
        DP_TMUL,
        DP_TDIV,
        DP_TACC,
        DP_CLAMP,
        DP_EMUL,
        DP_ERND,
        DP_ACC,
        DP_NORM_INIT,
        DP_NORM_FILL,
        DP_CUM_READ,
        DP_NORM_DIV,
        DP_NORM_WRITE,
        DP_Q_ADDR,
        DP_Q_READ,
        DP_Q_MUL,
        DP_RES_PREP,
        DP_RES_ZERO,
        DP_RES_QUERY
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   axis;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic entries_done;
        logic entry_edge;
        logic k_last;
        logic exp_go;
        logic norm_done;
        logic norm_fill;
        logic out_free;
    } dp_status_t;

    typedef struct packed {
        logic              one;
        logic [ADDR_W-1:0] addr;
    } axis_sel_t;

    function automatic logic [CNT_W-1:0] clamp_margin(input logic [MARGIN_W-1:0] v);
        if (int'(v) < 2) begin
            return CNT_W'(2);
        end
        if (int'(v) > MAX_MARGIN) begin
            return CNT_W'(MAX_MARGIN);
        end
        return CNT_W'(v);
    endfunction

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        if (v == '0) begin
            return SIZE_W'(1);
        end
        if (int'(v) > MAX_SIZE) begin
            return SIZE_W'(MAX_SIZE);
        end
        return v;
    endfunction

    function automatic axis_sel_t axis_sel(input logic [COORD_W-1:0]  c,
                                           input logic [SIZE_W-1:0]   size,
                                           input logic [MARGIN_W-1:0] margin);
        logic [SIZE_W-1:0] s;
        logic [SIZE_W-1:0] s1;
        logic [SIZE_W-1:0] m;
        logic [SIZE_W-1:0] cc;
        logic [SIZE_W-1:0] d;
        axis_sel_t         r;
        s  = clamp_size(size);
        s1 = s - SIZE_W'(1);
        m  = SIZE_W'(clamp_margin(margin));
        cc = SIZE_W'(c);
        if (cc > s1) begin
            cc = s1;
        end
        d      = s1 - cc;
        r.one  = 1'b0;
        r.addr = '0;
        if (cc < m) begin
            r.addr = cc[ADDR_W-1:0];
        end else if (cc + m >= s) begin
            r.addr = d[ADDR_W-1:0];
        end else begin
            r.one = 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== rtl/sepmol_div.sv =====
// Shared restoring divider that retires one quotient bit per cycle.
`include "assert_macros.svh"

module sepmol_div
    import sepmol_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DVD_W-1:0]  dividend,
    input  logic [DVS_W-1:0]  divisor,
    output logic              busy,
    output logic [DVD_W-1:0]  quotient,
    output logic [DVS_W-1:0]  remainder
);

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0]     q_reg;
    logic [DVS_W-1:0]     r_reg;
    logic [DVS_W-1:0]     d_reg;
    logic [DVS_W:0]       trial;
    logic [DVS_W:0]       diff;
    logic                 ge;

    always_comb
    begin
        trial = {r_reg, q_reg[DVD_W-1]};
        diff  = trial - {1'b0, d_reg};
        ge    = trial >= {1'b0, d_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(DVD_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[DVD_W-2:0], ge};
            r_reg <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign busy      = busy_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

    `ASSERT_IMPLY(a_div_no_restart, start, !busy_reg, "divider started while busy")

endmodule

// ===== rtl/sepmol_dp.sv =====
// Datapath of the mollifier window: configuration, taper build arithmetic, tables and query.
`include "assert_macros.svh"

module sepmol_dp
    import sepmol_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [COORD_W-1:0]    px,
    input  logic [COORD_W-1:0]    py,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COEF_W-1:0]     coefficient,
    output logic                  ready_res
);

    logic [SIZE_W-1:0]          width_reg;
    logic [SIZE_W-1:0]          height_reg;
    logic [MARGIN_W-1:0]        mx_reg;
    logic [MARGIN_W-1:0]        my_reg;
    logic                       out_valid_reg;
    logic [COEF_W-1:0]          coefficient_reg;
    logic                       ready_res_reg;

    logic [COORD_W-1:0]         px_reg;
    logic [COORD_W-1:0]         py_reg;
    logic [CNT_W-1:0]           m_reg;
    logic [CNT_W-1:0]           i_reg;
    logic [NUM_W-1:0]           num_reg;
    logic [NUM_W-1:0]           den_reg;
    logic [NUM_W-1:0]           n_reg;
    logic [FRAC_W-1:0]          f_reg;
    logic [FRAC_W-1:0]          term_reg;
    logic [K_W-1:0]             k_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic [FRAC_W:0]            r_reg;
    logic [TOTAL_W-1:0]         total_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic [TOTAL_W-1:0]         cum_rd_reg;
    axis_sel_t                  sel_x_reg;
    axis_sel_t                  sel_y_reg;
    logic [COEF_W-1:0]          tx_rd_reg;
    logic [COEF_W-1:0]          ty_rd_reg;

    logic [TOTAL_W-1:0]         cum_mem [MAX_MARGIN];
    logic [COEF_W-1:0]          tx_mem  [MAX_MARGIN];
    logic [COEF_W-1:0]          ty_mem  [MAX_MARGIN];

    logic                       div_start;
    logic [DVD_W-1:0]           div_dvd;
    logic [DVS_W-1:0]           div_dvs;
    logic                       div_busy;
    logic [DVD_W-1:0]           div_quo;
    logic [DVS_W-1:0]           div_rem;

    logic [CNT_W-1:0]           m_cl;
    logic [CNT_W-1:0]           span_m;
    logic [CNT_W-1:0]           span_i;
    logic [NUM_W-1:0]           den_prod;
    logic [PROD_W:0]            prod_rnd;
    logic [FRAC_W-1:0]          q32;
    logic [TOTAL_W-1:0]         total_sum;
    logic                       cum_we;
    logic [TOTAL_W-1:0]         cum_wdata;
    logic                       tap_we;
    logic [COEF_W-1:0]          tap_wdata;
    logic [COEF_W-1:0]          tx_sel;
    logic [COEF_W-1:0]          ty_sel;
    logic [QP_W-1:0]            q_prod;
    logic [QP_W-1:0]            q_rnd;

    sepmol_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        m_cl      = clamp_margin(cmd.axis ? my_reg : mx_reg);
        span_m    = m_cl - CNT_W'(1);
        span_i    = m_reg - CNT_W'(1) - i_reg;
        den_prod  = NUM_W'(i_reg[ADDR_W-1:0]) * NUM_W'(span_i[ADDR_W-1:0]);
        prod_rnd  = (PROD_W + 1)'(prod_reg) + HALF_Q32;
        q32       = div_quo[FRAC_W-1:0];
        total_sum = total_reg + TOTAL_W'(r_reg);
        tx_sel    = sel_x_reg.one ? ONE_Q15 : tx_rd_reg;
        ty_sel    = sel_y_reg.one ? ONE_Q15 : ty_rd_reg;
        q_prod    = QP_W'(tx_sel) * QP_W'(ty_sel);
        q_rnd     = prod_reg[QP_W-1:0] + HALF_Q15;

        cum_we    = (cmd.op == DP_EDGE_WRITE) || (cmd.op == DP_ACC);
        cum_wdata = (cmd.op == DP_ACC) ? total_sum : total_reg;
        tap_we    = (cmd.op == DP_NORM_FILL) || (cmd.op == DP_NORM_WRITE);
        tap_wdata = (cmd.op == DP_NORM_FILL) ? ONE_Q15 : div_quo[COEF_W-1:0];

        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = '0;
        case (cmd.op)
            DP_DIV_N:
            begin
                div_start = 1'b1;
                div_dvd   = DVD_W'(num_reg);
                div_dvs   = DVS_W'(den_reg);
            end
            DP_DIV_F:
            begin
                div_start = 1'b1;
                div_dvd   = DVD_W'({div_rem[NUM_W-1:0], {FRAC_W{1'b0}}});
                div_dvs   = DVS_W'(den_reg);
            end
            DP_TDIV:
            begin
                div_start = 1'b1;
                div_dvd   = DVD_W'(prod_rnd[PROD_W-1:FRAC_W]);
                div_dvs   = DVS_W'(k_reg);
            end
            DP_NORM_DIV:
            begin
                div_start = 1'b1;
                div_dvd   = DVD_W'({cum_rd_reg, {(COEF_W - 1){1'b0}}})
                          + DVD_W'(total_reg >> 1);
                div_dvs   = total_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_W'(256);
            height_reg <= SIZE_W'(256);
            mx_reg     <= MARGIN_W'(6);
            my_reg     <= MARGIN_W'(6);
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                REG_MARGIN_X:     mx_reg     <= cfg_data[MARGIN_W-1:0];
                REG_MARGIN_Y:     my_reg     <= cfg_data[MARGIN_W-1:0];
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((cmd.op == DP_RES_PREP) || (cmd.op == DP_RES_ZERO)
                 || (cmd.op == DP_RES_QUERY))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_CAPTURE:
            begin
                px_reg <= px;
                py_reg <= py;
            end
            DP_AXIS_INIT:
            begin
                m_reg     <= m_cl;
                i_reg     <= '0;
                total_reg <= '0;
                num_reg   <= NUM_W'(span_m[ADDR_W-1:0]) * NUM_W'(span_m[ADDR_W-1:0]);
            end
            DP_EDGE_WRITE:
            begin
                i_reg <= i_reg + CNT_W'(1);
            end
            DP_DEN:
            begin
                den_reg <= {den_prod[NUM_W-3:0], 2'b00};
            end
            DP_DIV_F:
            begin
                n_reg <= div_quo[NUM_W-1:0];
            end
            DP_TAYLOR1:
            begin
                f_reg    <= q32;
                term_reg <= q32;
                sum_reg  <= signed'(SUM_W'(ONE_Q32) - SUM_W'(q32));
                k_reg    <= K_W'(2);
            end
            DP_TMUL:
            begin
                prod_reg <= PROD_W'(term_reg) * PROD_W'(f_reg);
            end
            DP_TACC:
            begin
                term_reg <= q32;
                if (k_reg[0])
                begin
                    sum_reg <= sum_reg - signed'(SUM_W'(q32));
                end
                else
                begin
                    sum_reg <= sum_reg + signed'(SUM_W'(q32));
                end
                k_reg <= k_reg + K_W'(1);
            end
            DP_CLAMP:
            begin
                if (sum_reg[SUM_W-1])
                begin
                    r_reg <= '0;
                end
                else if (sum_reg > signed'(SUM_W'(ONE_Q32)))
                begin
                    r_reg <= ONE_Q32;
                end
                else
                begin
                    r_reg <= sum_reg[FRAC_W:0];
                end
            end
            DP_EMUL:
            begin
                prod_reg <= PROD_W'(r_reg) * PROD_W'(EXP_M1_Q32);
            end
            DP_ERND:
            begin
                r_reg <= {1'b0, prod_rnd[PROD_W-1:FRAC_W]};
                n_reg <= n_reg - NUM_W'(1);
            end
            DP_ACC:
            begin
                total_reg <= total_sum;
                i_reg     <= i_reg + CNT_W'(1);
            end
            DP_NORM_INIT:
            begin
                i_reg <= '0;
            end
            DP_NORM_FILL, DP_NORM_WRITE:
            begin
                i_reg <= i_reg + CNT_W'(1);
            end
            DP_Q_ADDR:
            begin
                sel_x_reg <= axis_sel(px_reg, width_reg, mx_reg);
                sel_y_reg <= axis_sel(py_reg, height_reg, my_reg);
            end
            DP_Q_MUL:
            begin
                prod_reg <= PROD_W'(q_prod);
            end
            DP_RES_PREP:
            begin
                coefficient_reg <= '0;
                ready_res_reg   <= 1'b1;
            end
            DP_RES_ZERO:
            begin
                coefficient_reg <= '0;
                ready_res_reg   <= 1'b0;
            end
            DP_RES_QUERY:
            begin
                coefficient_reg <= q_rnd[QP_W-2:COEF_W-1];
                ready_res_reg   <= 1'b1;
            end
            default:
            begin
                px_reg <= px_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cum_we)
        begin
            cum_mem[i_reg[ADDR_W-1:0]] <= cum_wdata;
        end
        if (cmd.op == DP_CUM_READ)
        begin
            cum_rd_reg <= cum_mem[i_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tap_we && !cmd.axis)
        begin
            tx_mem[i_reg[ADDR_W-1:0]] <= tap_wdata;
        end
        if (cmd.op == DP_Q_READ)
        begin
            tx_rd_reg <= tx_mem[sel_x_reg.addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tap_we && cmd.axis)
        begin
            ty_mem[i_reg[ADDR_W-1:0]] <= tap_wdata;
        end
        if (cmd.op == DP_Q_READ)
        begin
            ty_rd_reg <= ty_mem[sel_y_reg.addr];
        end
    end

    always_comb
    begin
        status.div_busy     = div_busy;
        status.entries_done = i_reg == m_reg;
        status.entry_edge   = (i_reg == '0) || (i_reg == m_reg - CNT_W'(1));
        status.k_last       = k_reg == K_W'(TAYLOR_TERMS);
        status.exp_go       = (n_reg != '0) && (r_reg != '0);
        status.norm_done    = i_reg == CNT_W'(MAX_MARGIN);
        status.norm_fill    = (i_reg >= m_reg) || (total_reg == '0);
        status.out_free     = !out_valid_reg || out_ready;
    end

    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign coefficient = coefficient_reg;
    assign ready_res   = ready_res_reg;

    `ASSERT_NEXT(a_query_coef_range, cmd.op == DP_RES_QUERY, coefficient_reg <= ONE_Q15,
                 "query coefficient above one")
    `ASSERT_IMPLY(a_result_room,
                  (cmd.op == DP_RES_PREP) || (cmd.op == DP_RES_ZERO) || (cmd.op == DP_RES_QUERY),
                  !out_valid_reg || out_ready, "result overwrites a pending beat")

endmodule

// ===== rtl/sepmol_ctrl.sv =====
// Controller state machine that sequences table builds and queries through the datapath.
`include "assert_macros.svh"

module sepmol_ctrl
    import sepmol_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       op,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [31:0] {
        S_IDLE    = 32'h0000_0001,
        S_B_INIT  = 32'h0000_0002,
        S_B_ENTRY = 32'h0000_0004,
        S_B_EDGE  = 32'h0000_0008,
        S_B_DEN   = 32'h0000_0010,
        S_B_DIVN  = 32'h0000_0020,
        S_B_WAITN = 32'h0000_0040,
        S_B_DIVF  = 32'h0000_0080,
        S_B_WAITF = 32'h0000_0100,
        S_T_FIRST = 32'h0000_0200,
        S_T_MUL   = 32'h0000_0400,
        S_T_DIV   = 32'h0000_0800,
        S_T_WAIT  = 32'h0000_1000,
        S_T_ACC   = 32'h0000_2000,
        S_E_CLAMP = 32'h0000_4000,
        S_E_CHECK = 32'h0000_8000,
        S_E_MUL   = 32'h0001_0000,
        S_E_RND   = 32'h0002_0000,
        S_B_ACC   = 32'h0004_0000,
        S_N_INIT  = 32'h0008_0000,
        S_N_ENTRY = 32'h0010_0000,
        S_N_FILL  = 32'h0020_0000,
        S_N_READ  = 32'h0040_0000,
        S_N_DIV   = 32'h0080_0000,
        S_N_WAIT  = 32'h0100_0000,
        S_N_WRITE = 32'h0200_0000,
        S_Q_ADDR  = 32'h0400_0000,
        S_Q_READ  = 32'h0800_0000,
        S_Q_MUL   = 32'h1000_0000,
        S_R_PREP  = 32'h2000_0000,
        S_R_ZERO  = 32'h4000_0000,
        S_R_QUERY = 32'h8000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   axis_reg;
    logic   axis_next;
    logic   built_reg;
    logic   built_next;

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        built_next = built_reg;
        cmd.op     = DP_NOP;
        cmd.axis   = axis_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = DP_CAPTURE;
                    if (op == OP_QUERY)
                    begin
                        state_next = built_reg ? S_Q_ADDR : S_R_ZERO;
                    end
                    else
                    begin
                        axis_next  = 1'b0;
                        state_next = S_B_INIT;
                    end
                end
            end
            S_B_INIT:
            begin
                cmd.op     = DP_AXIS_INIT;
                state_next = S_B_ENTRY;
            end
            S_B_ENTRY:
            begin
                if (status.entries_done)
                begin
                    state_next = S_N_INIT;
                end
                else if (status.entry_edge)
                begin
                    state_next = S_B_EDGE;
                end
                else
                begin
                    state_next = S_B_DEN;
                end
            end
            S_B_EDGE:
            begin
                cmd.op     = DP_EDGE_WRITE;
                state_next = S_B_ENTRY;
            end
            S_B_DEN:
            begin
                cmd.op     = DP_DEN;
                state_next = S_B_DIVN;
            end
            S_B_DIVN:
            begin
                cmd.op     = DP_DIV_N;
                state_next = S_B_WAITN;
            end
            S_B_WAITN:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_B_DIVF;
                end
            end
            S_B_DIVF:
            begin
                cmd.op     = DP_DIV_F;
                state_next = S_B_WAITF;
            end
            S_B_WAITF:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_T_FIRST;
                end
            end
            S_T_FIRST:
            begin
                cmd.op     = DP_TAYLOR1;
                state_next = S_T_MUL;
            end
            S_T_MUL:
            begin
                cmd.op     = DP_TMUL;
                state_next = S_T_DIV;
            end
            S_T_DIV:
            begin
                cmd.op     = DP_TDIV;
                state_next = S_T_WAIT;
            end
            S_T_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_T_ACC;
                end
            end
            S_T_ACC:
            begin
                cmd.op     = DP_TACC;
                state_next = status.k_last ? S_E_CLAMP : S_T_MUL;
            end
            S_E_CLAMP:
            begin
                cmd.op     = DP_CLAMP;
                state_next = S_E_CHECK;
            end
            S_E_CHECK:
            begin
                state_next = status.exp_go ? S_E_MUL : S_B_ACC;
            end
            S_E_MUL:
            begin
                cmd.op     = DP_EMUL;
                state_next = S_E_RND;
            end
            S_E_RND:
            begin
                cmd.op     = DP_ERND;
                state_next = S_E_CHECK;
            end
            S_B_ACC:
            begin
                cmd.op     = DP_ACC;
                state_next = S_B_ENTRY;
            end
            S_N_INIT:
            begin
                cmd.op     = DP_NORM_INIT;
                state_next = S_N_ENTRY;
            end
            S_N_ENTRY:
            begin
                if (status.norm_done)
                begin
                    if (!axis_reg)
                    begin
                        axis_next  = 1'b1;
                        state_next = S_B_INIT;
                    end
                    else
                    begin
                        built_next = 1'b1;
                        state_next = S_R_PREP;
                    end
                end
                else if (status.norm_fill)
                begin
                    state_next = S_N_FILL;
                end
                else
                begin
                    state_next = S_N_READ;
                end
            end
            S_N_FILL:
            begin
                cmd.op     = DP_NORM_FILL;
                state_next = S_N_ENTRY;
            end
            S_N_READ:
            begin
                cmd.op     = DP_CUM_READ;
                state_next = S_N_DIV;
            end
            S_N_DIV:
            begin
                cmd.op     = DP_NORM_DIV;
                state_next = S_N_WAIT;
            end
            S_N_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_N_WRITE;
                end
            end
            S_N_WRITE:
            begin
                cmd.op     = DP_NORM_WRITE;
                state_next = S_N_ENTRY;
            end
            S_Q_ADDR:
            begin
                cmd.op     = DP_Q_ADDR;
                state_next = S_Q_READ;
            end
            S_Q_READ:
            begin
                cmd.op     = DP_Q_READ;
                state_next = S_Q_MUL;
            end
            S_Q_MUL:
            begin
                cmd.op     = DP_Q_MUL;
                state_next = S_R_QUERY;
            end
            S_R_PREP:
            begin
                if (status.out_free)
                begin
                    cmd.op     = DP_RES_PREP;
                    state_next = S_IDLE;
                end
            end
            S_R_ZERO:
            begin
                if (status.out_free)
                begin
                    cmd.op     = DP_RES_ZERO;
                    state_next = S_IDLE;
                end
            end
            S_R_QUERY:
            begin
                if (status.out_free)
                begin
                    cmd.op     = DP_RES_QUERY;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= 1'b0;
            built_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            built_reg <= built_next;
        end
    end

    assign in_ready = state_reg == S_IDLE;

    `ASSERT_NEXT(a_built_sticky, built_reg, built_reg, "tables built flag dropped")
    `ASSERT_IMPLY(a_query_after_build, state_reg == S_Q_ADDR, built_reg,
                  "table lookup before any build")

endmodule

// ===== rtl/separable_mollifier_window.sv =====
// Top level of the separable mollifier edge-taper window block.
//
//   Channel  Handshake              Payload
//   cfg      cfg_valid/cfg_ready    cfg_index (2), cfg_data (13)
//   in       in_valid/in_ready      op (1), px (12), py (12)
//   out      out_valid/out_ready    coefficient (16), ready_res (1)
//
// A query reads both tapers, multiplies them and registers the result once out is free.
// A prepare builds x then y: each interior taper entry costs 14 divisions of 56 quotient
// bits (issue, shift, handoff) plus a multiply and round per e^-1 scaling step, and each
// axis is then normalized over 256 entries, dividing only for entries inside the margin.
// Reset clears control and sets the config defaults; tables are empty until a prepare.
// A finished result waits in the output register while the next beat is accepted.
module separable_mollifier_window
    import sepmol_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  op,
    input  logic [COORD_W-1:0]    px,
    input  logic [COORD_W-1:0]    py,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COEF_W-1:0]     coefficient,
    output logic                  ready_res
);

    dp_cmd_t    cmd;
    dp_status_t status;

    sepmol_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op),
        .status   (status),
        .cmd      (cmd)
    );

    sepmol_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .px          (px),
        .py          (py),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .coefficient (coefficient),
        .ready_res   (ready_res)
    );

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for separable_mollifier_window: directed table, then random phases.
`timescale 1ns / 100ps

module tb_top;
    import sepmol_pkg::*;

    localparam int          WATCHDOG_LIMIT = 1500000;
    localparam int          DRAIN_CYCLES   = 20;
    localparam int          HOLD_CYCLES    = 250;
    localparam int          NUM_PHASES     = 10;
    localparam int          NUM_ROWS       = 15;
    localparam logic [15:0] Q15_ONE        = 16'd32768;

    typedef logic [COEF_W-1:0] taper_t [MAX_MARGIN];

    typedef struct {
        logic [COEF_W-1:0] coef;
        logic              rdy;
    } window_beat_t;

    typedef struct {
        logic              op_code;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        bit                known;
        logic [COEF_W-1:0] coef;
        logic              rdy;
    } stim_row_t;

    typedef struct {
        int w;
        int h;
        int mx;
        int my;
        bit prep_first;
        bit prep_rand;
        int items;
        int idle_pct;
        bit hold;
        bit rand_cfg;
    } phase_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic                  op;
    logic [COORD_W-1:0]    px;
    logic [COORD_W-1:0]    py;
    logic                  out_valid;
    logic                  out_ready;
    logic [COEF_W-1:0]     coefficient;
    logic                  ready_res;

    taper_t       taper_x_m;
    taper_t       taper_y_m;
    bit           built_m;
    int unsigned  width_m;
    int unsigned  height_m;
    int unsigned  margin_x_m;
    int unsigned  margin_y_m;

    window_beat_t coef_q[$];
    int           err_cnt;
    int           query_cnt;
    int           prep_cnt;
    int           cfg_cnt;
    int           beat_cnt;
    int           idle_pct;
    bit           hold_req;
    int           stall_cycles;

    separable_mollifier_window u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .px          (px),
        .py          (py),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .coefficient (coefficient),
        .ready_res   (ready_res)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint unsigned q32_mul(longint unsigned a, longint unsigned b);
        return (a * b + 64'h8000_0000) >> 32;
    endfunction

    function automatic longint unsigned mollifier_exp(longint unsigned num,
                                                      longint unsigned den);
        longint unsigned n;
        longint unsigned f;
        longint unsigned term;
        longint unsigned r;
        longint          acc;
        n    = num / den;
        f    = ((num % den) << 32) / den;
        term = 64'h1_0000_0000;
        acc  = 64'h1_0000_0000;
        for (int k = 1; k <= TAYLOR_TERMS; k++)
        begin
            term = q32_mul(term, f) / longint'(k);
            if (k % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        r = longint'(acc);
        if (r > 64'h1_0000_0000)
            r = 64'h1_0000_0000;
        while (n > 0 && r != 0)
        begin
            r = q32_mul(r, longint'(EXP_M1_Q32));
            n--;
        end
        return r;
    endfunction

    function automatic int unsigned margin_eff(int unsigned v);
        if (v < 2)
            return 2;
        if (v > MAX_MARGIN)
            return MAX_MARGIN;
        return v;
    endfunction

    function automatic int unsigned size_eff(int unsigned v);
        if (v < 1)
            return 1;
        if (v > MAX_SIZE)
            return MAX_SIZE;
        return v;
    endfunction

    function automatic taper_t build_taper(int unsigned mreg);
        taper_t          tab;
        longint unsigned cum [MAX_MARGIN];
        longint unsigned total;
        longint unsigned span;
        int unsigned     m;
        m     = margin_eff(mreg);
        span  = m - 1;
        total = 0;
        for (int i = 0; i < m; i++)
        begin
            if (i != 0 && i != m - 1)
                total += mollifier_exp(span * span, 4 * longint'(i) * longint'(m - 1 - i));
            cum[i] = total;
        end
        for (int i = 0; i < MAX_MARGIN; i++)
        begin
            if (i >= m || total == 0)
                tab[i] = Q15_ONE;
            else
                tab[i] = COEF_W'((cum[i] * 32768 + total / 2) / total);
        end
        return tab;
    endfunction

    function automatic int unsigned taper_coef(taper_t tab, int unsigned c,
                                               int unsigned sreg, int unsigned mreg);
        int unsigned s;
        int unsigned m;
        s = size_eff(sreg);
        m = margin_eff(mreg);
        if (c > s - 1)
            c = s - 1;
        if (c < m)
            return tab[c];
        if (c + m >= s)
            return tab[s - 1 - c];
        return Q15_ONE;
    endfunction

    function automatic window_beat_t window_predict(logic o, logic [COORD_W-1:0] x,
                                                    logic [COORD_W-1:0] y);
        window_beat_t b;
        int unsigned  tx;
        int unsigned  ty;
        b.coef = '0;
        b.rdy  = 1'b0;
        if (o == OP_PREPARE)
        begin
            taper_x_m = build_taper(margin_x_m);
            taper_y_m = build_taper(margin_y_m);
            built_m   = 1'b1;
            b.rdy     = 1'b1;
        end
        else if (built_m)
        begin
            tx     = taper_coef(taper_x_m, x, width_m, margin_x_m);
            ty     = taper_coef(taper_y_m, y, height_m, margin_y_m);
            b.coef = COEF_W'((tx * ty + 16384) >> 15);
            b.rdy  = 1'b1;
        end
        return b;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d (beat %0d)", what, got, want, beat_cnt);
        err_cnt++;
    endtask

    task automatic send_item(logic o, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             bit known, logic [COEF_W-1:0] kc, logic kr);
        window_beat_t b;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= o;
        px       <= x;
        py       <= y;
        do
            @(posedge clk);
        while (!in_ready);
        b = window_predict(o, x, y);
        if (known)
        begin
            b.coef = kc;
            b.rdy  = kr;
        end
        coef_q.push_back(b);
        if (o == OP_PREPARE)
            prep_cnt++;
        else
            query_cnt++;
    endtask

    task automatic write_reg(cfg_reg_t idx, int unsigned val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_IMAGE_WIDTH:  width_m    = val & 13'h1FFF;
            REG_IMAGE_HEIGHT: height_m   = val & 13'h1FFF;
            REG_MARGIN_X:     margin_x_m = val & 9'h1FF;
            REG_MARGIN_Y:     margin_y_m = val & 9'h1FF;
            default: ;
        endcase
        cfg_cnt++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (coef_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [COORD_W-1:0] pick_coord(int unsigned sreg, int unsigned mreg);
        int s;
        int m;
        int c;
        s = size_eff(sreg);
        m = margin_eff(mreg);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: c = $urandom_range(0, m + 2);
            4, 5, 6:    c = s - 1 - int'($urandom_range(0, m + 2));
            7, 8:       c = $urandom_range(0, 4095);
            default:    c = (s < 4096) ? int'($urandom_range(s, 4095)) : 4095;
        endcase
        if (c < 0)
            c = 0;
        if (c > 4095)
            c = 4095;
        return COORD_W'(c);
    endfunction

    always @(posedge clk)
    begin
        window_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            beat_cnt++;
            if (coef_q.size() == 0)
            begin
                report_mismatch("unexpected result beat, coefficient", coefficient, -1);
            end
            else
            begin
                want = coef_q.pop_front();
                if (coefficient !== want.coef)
                    report_mismatch("coefficient", coefficient, want.coef);
                if (ready_res !== want.rdy)
                    report_mismatch("ready_res", ready_res, want.rdy);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no beat for %0d cycles", stall_cycles);
            $display("** separable_mollifier_window: FAILED **");
            $finish;
        end
    end

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        stim_row_t rows [NUM_ROWS];
        phase_t    phases [NUM_PHASES];
        phase_t    ph;
        logic      o;

        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_IMAGE_WIDTH;
        cfg_data     = '0;
        in_valid     = 1'b0;
        op           = OP_QUERY;
        px           = '0;
        py           = '0;
        err_cnt      = 0;
        query_cnt    = 0;
        prep_cnt     = 0;
        cfg_cnt      = 0;
        beat_cnt     = 0;
        stall_cycles = 0;
        hold_req     = 1'b0;
        idle_pct     = 20;
        built_m      = 1'b0;
        width_m      = 256;
        height_m     = 256;
        margin_x_m   = 6;
        margin_y_m   = 6;

        rows = '{
            '{OP_QUERY,   12'd0,    12'd0,    1'b1, 16'd0,     1'b0},
            '{OP_QUERY,   12'd4095, 12'd4095, 1'b1, 16'd0,     1'b0},
            '{OP_PREPARE, 12'd4095, 12'd4095, 1'b1, 16'd0,     1'b1},
            '{OP_QUERY,   12'd0,    12'd0,    1'b1, 16'd0,     1'b1},
            '{OP_QUERY,   12'd128,  12'd128,  1'b1, 16'd32768, 1'b1},
            '{OP_QUERY,   12'd5,    12'd128,  1'b1, 16'd32768, 1'b1},
            '{OP_QUERY,   12'd255,  12'd255,  1'b1, 16'd0,     1'b1},
            '{OP_QUERY,   12'd4095, 12'd100,  1'b1, 16'd0,     1'b1},
            '{OP_QUERY,   12'd1,    12'd128,  1'b0, 16'd0,     1'b0},
            '{OP_QUERY,   12'd2,    12'd3,    1'b0, 16'd0,     1'b0},
            '{OP_QUERY,   12'd250,  12'd251,  1'b0, 16'd0,     1'b0},
            '{OP_QUERY,   12'd128,  12'd4,    1'b0, 16'd0,     1'b0},
            '{OP_QUERY,   12'd4,    12'd252,  1'b0, 16'd0,     1'b0},
            '{OP_PREPARE, 12'd0,    12'd0,    1'b1, 16'd0,     1'b1},
            '{OP_QUERY,   12'd3,    12'd3,    1'b0, 16'd0,     1'b0}
        };

        // Large margins make a prepare very slow, so only one phase builds them; the next two
        // phases change the registers and query the stored tables without rebuilding.
        phases = '{
            '{1,    1,    2,   2,   1'b1, 1'b1, 150, 30, 1'b0, 1'b0},
            '{10,   7,    8,   5,   1'b1, 1'b1, 150, 30, 1'b0, 1'b0},
            '{4096, 4096, 256, 256, 1'b1, 1'b0, 200, 30, 1'b0, 1'b0},
            '{8191, 0,    511, 0,   1'b0, 1'b0, 200, 40, 1'b1, 1'b0},
            '{0,    8191, 1,   300, 1'b0, 1'b0, 150, 20, 1'b0, 1'b0},
            '{0,    0,    0,   0,   1'b1, 1'b1, 200, 25, 1'b0, 1'b1},
            '{0,    0,    0,   0,   1'b1, 1'b1, 200, 0,  1'b0, 1'b1},
            '{0,    0,    0,   0,   1'b1, 1'b1, 200, 25, 1'b0, 1'b1},
            '{0,    0,    0,   0,   1'b1, 1'b1, 200, 35, 1'b0, 1'b1},
            '{0,    0,    0,   0,   1'b1, 1'b1, 200, 0,  1'b0, 1'b1}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < NUM_ROWS; r++)
            send_item(rows[r].op_code, rows[r].x, rows[r].y, rows[r].known,
                      rows[r].coef, rows[r].rdy);
        wait_drained();

        foreach (phases[p])
        begin
            ph = phases[p];
            if (ph.rand_cfg)
            begin
                ph.w  = $urandom_range(1, 4096);
                ph.h  = $urandom_range(1, 4096);
                ph.mx = $urandom_range(2, 12);
                ph.my = $urandom_range(2, 12);
            end
            idle_pct = ph.idle_pct;
            write_reg(REG_IMAGE_WIDTH, ph.w);
            write_reg(REG_IMAGE_HEIGHT, ph.h);
            write_reg(REG_MARGIN_X, ph.mx);
            write_reg(REG_MARGIN_Y, ph.my);
            cfg_valid <= 1'b0;
            if (ph.prep_first)
                send_item(OP_PREPARE, COORD_W'($urandom), COORD_W'($urandom), 1'b0, '0, 1'b0);
            if (ph.hold)
                hold_req = 1'b1;
            for (int i = 0; i < ph.items; i++)
            begin
                o = (ph.prep_rand && $urandom_range(0, 99) == 0) ? OP_PREPARE : OP_QUERY;
                send_item(o, pick_coord(width_m, margin_x_m), pick_coord(height_m, margin_y_m),
                          1'b0, '0, 1'b0);
            end
            wait_drained();
        end

        $display("Covered %0d queries and %0d prepares over %0d register writes;",
                 query_cnt, prep_cnt, cfg_cnt);
        $display("margins from 2 to 256 and sizes from 1 to 4096, with clamped values.");
        if (err_cnt == 0)
            $display("** separable_mollifier_window: PASSED **");
        else
            $display("** separable_mollifier_window: FAILED **");
        $finish;
    end

endmodule
